// ===== hw/rtl/dapm_pkg.sv =====
// Shared types and constants for the dual-axis proportional move controller.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package dapm_pkg;

    localparam int POS_W    = 16;
    localparam int ERR_W    = POS_W + 1;
    localparam int GAIN_W   = 12;
    localparam int PROD_W   = ERR_W + GAIN_W + 1;
    localparam int SPEED_W  = 16;
    localparam int PCT_W    = 7;
    localparam int LIMIT_W  = PCT_W + 8;
    localparam int RANGE_W  = 15;
    localparam int COUNT_W  = 16;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 16;

    localparam logic [PCT_W-1:0]   PCT_CAP   = PCT_W'(100);
    localparam logic [SPEED_W-1:0] ACCEL_Q8  = SPEED_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_TARGET   = 3'd0,
        CFG_MAXSPEED = 3'd1,
        CFG_GAIN     = 3'd2,
        CFG_RANGE    = 3'd3,
        CFG_DELAY    = 3'd4
    } cfg_addr_t;

    typedef struct packed {
        logic clear;
        logic step;
    } lane_ctrl_t;

    typedef struct packed {
        logic                      far;
        logic signed [SPEED_W-1:0] speed;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dapm_lane.sv =====
// One channel of the controller: error, proportional proposal, slew and clamp.
// Holds the channel speed register. Depends on dapm_pkg.
`default_nettype none

module dapm_lane (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dapm_pkg::lane_ctrl_t              ctrl,
    input  wire logic signed [dapm_pkg::POS_W-1:0] position,
    input  wire logic signed [dapm_pkg::POS_W-1:0] target,
    input  wire logic [dapm_pkg::GAIN_W-1:0]       gain,
    input  wire logic [dapm_pkg::LIMIT_W-1:0]      limit,
    input  wire logic [dapm_pkg::RANGE_W-1:0]      settle_range,
    output dapm_pkg::lane_res_t                    res
);
    import dapm_pkg::*;

    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          mag;
    logic signed [PROD_W-1:0]  prod, spd_w, cand, lim_w;

    always_comb begin
        err   = ERR_W'(target) - ERR_W'(position);
        mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        prod  = PROD_W'(err) * $signed({1'b0, gain});
        spd_w = PROD_W'(speed_reg);
        lim_w = $signed(PROD_W'(limit));
        if (prod > spd_w) begin
            cand = spd_w + $signed(PROD_W'(ACCEL_Q8));
        end else begin
            cand = prod;
        end
        if (cand > lim_w) begin
            cand = lim_w;
        end
        if (cand < -lim_w) begin
            cand = -lim_w;
        end
        speed_next = cand[SPEED_W-1:0];
        res.far    = mag > ERR_W'(settle_range);
        res.speed  = speed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            speed_reg <= '0;
        end else if (ctrl.step) begin
            speed_reg <= speed_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dapm_merge.sv =====
// Merging stage: combines both lanes into the settle counter, done flag and result register.
// Depends on dapm_pkg.
`default_nettype none

module dapm_merge (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    input  wire logic                                op,
    input  wire dapm_pkg::lane_res_t                 left_res,
    input  wire dapm_pkg::lane_res_t                 right_res,
    input  wire logic [dapm_pkg::COUNT_W-1:0]        settle_delay,
    input  wire logic                                m_ready,
    output logic                                     finished,
    output logic                                     m_valid,
    output logic signed [dapm_pkg::SPEED_W-1:0]      m_left,
    output logic signed [dapm_pkg::SPEED_W-1:0]      m_right,
    output logic                                     m_done
);
    import dapm_pkg::*;

    logic [COUNT_W-1:0]        count_reg, count_next, cnt;
    logic                      finished_reg, finished_next;
    logic                      valid_reg;
    logic signed [SPEED_W-1:0] left_reg, right_reg, left_next, right_next;
    logic                      done_reg, done_next;

    always_comb begin
        count_next    = count_reg;
        finished_next = finished_reg;
        left_next     = '0;
        right_next    = '0;
        done_next     = 1'b0;
        cnt           = (left_res.far && right_res.far) ? '0 : count_reg;
        if (op == OP_START) begin
            count_next    = '0;
            finished_next = 1'b0;
        end else if (finished_reg) begin
            done_next = 1'b1;
        end else if (cnt > settle_delay) begin
            count_next    = cnt;
            finished_next = 1'b1;
            done_next     = 1'b1;
        end else begin
            count_next = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
            left_next  = left_res.speed;
            right_next = right_res.speed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            finished_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else if (accept) begin
            count_reg    <= count_next;
            finished_reg <= finished_next;
            valid_reg    <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            done_reg  <= done_next;
        end
    end

    assign finished = finished_reg;
    assign m_valid  = valid_reg;
    assign m_left   = left_reg;
    assign m_right  = right_reg;
    assign m_done   = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_axis_p_move_with_slew_settle.sv =====
// Top level of the dual-axis proportional move controller with slew limit and settle detection.
// Holds the configuration registers and joins two dapm_lane copies with dapm_merge.
// Depends on dapm_pkg, dapm_lane and dapm_merge.
//
//   Port group   Direction  Contents
//   s_axis_*     in         tuser = op, tdata = left_position, right_position
//   m_axis_*     out        tuser = done_res, tdata = left_drive, right_drive
//   cfg_*        in         register index and write data, no read-back
//
// Each transaction is processed in its accept cycle: one item per cycle unless output stalls.
// The lane multiply, slew compare and clamp form the longest path into the speed registers.
// The single result register frees in the same cycle it is taken, so input stalls only follow
// output stalls. Reset is synchronous and clears speeds, settle count and the done flag.
`default_nettype none

module dual_axis_p_move_with_slew_settle (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [31:0]                     s_axis_tdata,  // left_position, right_position
    input  wire logic                            s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // left_drive, right_drive
    output logic                                 m_axis_tuser,  // done_res
    input  wire logic                            cfg_wr_en,
    input  wire logic [dapm_pkg::CFG_A_W-1:0]    cfg_addr,
    input  wire logic [dapm_pkg::CFG_D_W-1:0]    cfg_wr_data
);
    import dapm_pkg::*;

    logic signed [POS_W-1:0] target_reg;
    logic [PCT_W-1:0]        max_speed_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [RANGE_W-1:0]      range_reg;
    logic [COUNT_W-1:0]      delay_reg;
    logic [PCT_W-1:0]        pct;
    logic [LIMIT_W-1:0]      limit;
    logic                    accept, finished;
    lane_ctrl_t              ctrl;
    lane_res_t               left_res, right_res;
    logic signed [SPEED_W-1:0] m_left, m_right;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= '0;
            max_speed_reg <= PCT_CAP;
            gain_reg      <= GAIN_W'(128);
            range_reg     <= RANGE_W'(5);
            delay_reg     <= COUNT_W'(20);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TARGET:   target_reg    <= cfg_wr_data[POS_W-1:0];
                CFG_MAXSPEED: max_speed_reg <= cfg_wr_data[PCT_W-1:0];
                CFG_GAIN:     gain_reg      <= cfg_wr_data[GAIN_W-1:0];
                CFG_RANGE:    range_reg     <= cfg_wr_data[RANGE_W-1:0];
                CFG_DELAY:    delay_reg     <= cfg_wr_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign pct           = (max_speed_reg > PCT_CAP) ? PCT_CAP : max_speed_reg;
    assign limit         = {pct, 8'b0};
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctrl.clear    = accept && (s_axis_tuser == OP_START);
    assign ctrl.step     = accept && (s_axis_tuser == OP_TICK) && !finished;

    dapm_lane u_lane_left (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .position     (s_axis_tdata[15:0]),
        .target       (target_reg),
        .gain         (gain_reg),
        .limit        (limit),
        .settle_range (range_reg),
        .res          (left_res)
    );

    dapm_lane u_lane_right (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .position     (s_axis_tdata[31:16]),
        .target       (target_reg),
        .gain         (gain_reg),
        .limit        (limit),
        .settle_range (range_reg),
        .res          (right_res)
    );

    dapm_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (s_axis_tuser),
        .left_res     (left_res),
        .right_res    (right_res),
        .settle_delay (delay_reg),
        .m_ready      (m_axis_tready),
        .finished     (finished),
        .m_valid      (m_axis_tvalid),
        .m_left       (m_left),
        .m_right      (m_right),
        .m_done       (m_axis_tuser)
    );

    assign m_axis_tdata = {m_right, m_left};

    // A done result always carries stopped motors.
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("done result with nonzero drive");

    // A start transaction produces a zero, not-done result next cycle.
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser == OP_START) |=>
        (m_axis_tvalid && !m_axis_tuser && m_axis_tdata == '0))
        else $error("start transaction gave wrong result");

    // Once finished, ticks keep reporting done.
    a_finished_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser == OP_TICK && finished) |=> (m_axis_tuser && finished))
        else $error("finished move lost its done state");

    // The lanes never advance while the move is finished.
    a_no_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        finished |-> !ctrl.step)
        else $error("lane stepped after the move finished");

endmodule

`default_nettype wire

// ===== bench/dual_axis_p_move_with_slew_settle_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the dual-axis proportional move controller: predicts every drive
// result from the accepted sample and start transactions and compares it with the output stream.
// Depends on dapm_pkg and dual_axis_p_move_with_slew_settle.

module dual_axis_p_move_with_slew_settle_tb;
    import dapm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               done;
    } drive_t;

    class drive_scoreboard;
        logic signed [15:0] target;
        logic [6:0]         max_pct;
        logic [11:0]        gain;
        logic [14:0]        near_band;
        logic [15:0]        settle_delay;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [15:0]        settle_count;
        bit                 finished;
        drive_t             expected_drives[$];
        int                 errors;

        function new();
            target       = 16'sd0;
            max_pct      = 7'd100;
            gain         = 12'd128;
            near_band    = 15'd5;
            settle_delay = 16'd20;
            left_speed   = 16'sd0;
            right_speed  = 16'sd0;
            settle_count = 16'd0;
            finished     = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(cfg_addr_t idx, logic [15:0] value);
            case (idx)
                CFG_TARGET:   target       = value;
                CFG_MAXSPEED: max_pct      = value[6:0];
                CFG_GAIN:     gain         = value[11:0];
                CFG_RANGE:    near_band    = value[14:0];
                CFG_DELAY:    settle_delay = value;
                default: ;
            endcase
        endfunction

        function logic signed [15:0] slew_speed(logic signed [15:0] speed, longint err,
                                                longint limit);
            longint proposal;
            longint s;
            proposal = err * longint'(gain);
            s = longint'(speed);
            if (proposal > s) begin
                s = s + longint'(ACCEL_Q8);
            end else begin
                s = proposal;
            end
            if (s > limit) s = limit;
            if (s < -limit) s = -limit;
            return 16'(s);
        endfunction

        function void predict_drive(op_t op, logic [31:0] data);
            drive_t d;
            longint lerr;
            longint rerr;
            longint limit;
            longint lmag;
            longint rmag;
            d = '0;
            if (op == OP_START) begin
                left_speed   = 16'sd0;
                right_speed  = 16'sd0;
                settle_count = 16'd0;
                finished     = 1'b0;
            end else if (finished) begin
                d.done = 1'b1;
            end else begin
                lerr  = longint'(target) - longint'($signed(data[15:0]));
                rerr  = longint'(target) - longint'($signed(data[31:16]));
                limit = (max_pct > 7'd100 ? 100 : longint'(max_pct)) * 256;
                left_speed  = slew_speed(left_speed, lerr, limit);
                right_speed = slew_speed(right_speed, rerr, limit);
                lmag = lerr < 0 ? -lerr : lerr;
                rmag = rerr < 0 ? -rerr : rerr;
                if (lmag > longint'(near_band) && rmag > longint'(near_band)) begin
                    settle_count = 16'd0;
                end
                if (settle_count > settle_delay) begin
                    finished = 1'b1;
                    d.done   = 1'b1;
                end else begin
                    if (settle_count != COUNT_MAX) settle_count++;
                    d.left  = left_speed;
                    d.right = right_speed;
                end
            end
            expected_drives.push_back(d);
        endfunction

        function void check_drive(logic [31:0] data, logic done);
            drive_t want;
            drive_t got;
            got.left  = data[15:0];
            got.right = data[31:16];
            got.done  = done;
            if (expected_drives.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: left %0d right %0d done %0b",
                             got.left, got.right, got.done);
                end
                return;
            end
            want = expected_drives.pop_front();
            if (got.left !== want.left || got.right !== want.right || got.done !== want.done)
            begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected left %0d right %0d done %0b,",
                             want.left, want.right, want.done,
                             " got left %0d right %0d done %0b",
                             got.left, got.right, got.done);
                end
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    op_t         s_axis_tuser  = OP_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_wr_en     = 1'b0;
    cfg_addr_t   cfg_addr      = CFG_TARGET;
    logic [15:0] cfg_wr_data   = '0;

    drive_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    dual_axis_p_move_with_slew_settle dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Inputs are noted before outputs are checked so that prediction never lags a result.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.predict_drive(s_axis_tuser, s_axis_tdata);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_drive(m_axis_tdata, m_axis_tuser);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(op_t op, logic [15:0] left_pos, logic [15:0] right_pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {right_pos, left_pos};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_drives.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_addr_t idx, logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(logic [15:0] tgt, logic [6:0] spd, logic [11:0] g,
                                  logic [14:0] band, logic [15:0] dly);
        cfg_write(CFG_TARGET, tgt);
        cfg_write(CFG_MAXSPEED, 16'(spd));
        cfg_write(CFG_GAIN, 16'(g));
        cfg_write(CFG_RANGE, 16'(band));
        cfg_write(CFG_DELAY, dly);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Most positions land near the target so that moves actually settle.
    function automatic logic [15:0] pick_position();
        int roll;
        int span;
        int offset;
        roll = $urandom_range(99);
        if (roll < 60) begin
            span = int'(sb.near_band) + 2;
        end else if (roll < 85) begin
            span = 300;
        end else begin
            return 16'($urandom);
        end
        offset = int'($urandom_range(2 * span)) - span;
        return 16'(int'(sb.target) + offset);
    endfunction

    task automatic run_moves(int count);
        int sent;
        int ticks;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 10) begin
                send_item(op_t'($urandom_range(1)), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                send_item(OP_START, 16'($urandom), 16'($urandom));
                sent++;
                ticks = $urandom_range(2, 30);
                for (int k = 0; k < ticks; k++) begin
                    send_item(OP_TICK, pick_position(), pick_position());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(OP_START, 16'h8000, 16'h7FFF);
        send_item(OP_TICK, 16'h8000, 16'h7FFF);
        send_item(OP_TICK, 16'h7FFF, 16'h8000);
        send_item(OP_TICK, 16'h0000, 16'hFFFF);
        wait_drained();

        apply_settings(16'h0000, 7'd127, 12'd4095, 15'd3, 16'd1);
        send_item(OP_START, 16'hFFFF, 16'h0000);
        send_item(OP_TICK, 16'd1, 16'hFFFF);
        send_item(OP_TICK, 16'd2, 16'd2);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_TICK, 16'h8000, 16'h8000);
        send_item(OP_START, 16'd0, 16'd0);
        send_item(OP_TICK, 16'd100, 16'd0);
        send_item(OP_TICK, 16'd100, 16'hFF9C);
        send_item(OP_TICK, 16'hFFFC, 16'd4);
        send_item(OP_TICK, 16'd3, 16'd3);
        send_item(OP_START, 16'd0, 16'd0);
        send_item(OP_TICK, 16'h8000, 16'h8000);
        send_item(OP_TICK, 16'h7FFF, 16'h7FFF);
        wait_drained();

        apply_settings(16'h8000, 7'd0, 12'd0, 15'd0, 16'd0);
        send_item(OP_START, 16'd0, 16'd0);
        send_item(OP_TICK, 16'h7FFF, 16'h8000);
        send_item(OP_TICK, 16'h7FFF, 16'h8000);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct  = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 36 : 0;
            recv_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 36 : 0;
            case (p)
                0: apply_settings(16'h0000, 7'd100, 12'd128, 15'd5, 16'd3);
                1: apply_settings(16'h8000, 7'd127, 12'd4095, 15'd0, 16'd0);
                2: apply_settings(16'h7FFF, 7'd0, 12'd0, 15'd32767, 16'd65535);
                3: apply_settings(16'($urandom), 7'($urandom_range(127)), 12'($urandom),
                                  15'($urandom_range(64)), 16'($urandom_range(12)));
                4: apply_settings(16'($urandom), 7'd50, 12'($urandom), 15'd20, 16'd5);
                default: apply_settings(16'd1234, 7'd101, 12'd1, 15'd3, 16'd1);
            endcase
            run_moves(48);
            wait_drained();
            run_moves(48);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
